>>> rtl/core/i2c_master_transfer_sequencer_macros.svh
// Assertion helpers shared by the RTL.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, skipped while reset is asserted.
`define I2CMTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2cmts assertion failed");

// Condition that must never be seen at a clock edge.
`define I2CMTS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("i2cmts forbidden condition seen");

`else

`define I2CMTS_ASSERT(label, clk, rst_n, prop)
`define I2CMTS_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> rtl/core/i2cmts_pkg.sv
`timescale 1ns / 1ps

package i2cmts_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 16;

  // request opcodes
  localparam logic [1:0] OP_START_TX = 2'd0;
  localparam logic [1:0] OP_START_RX = 2'd1;
  localparam logic [1:0] OP_EVENT    = 2'd2;
  localparam logic [1:0] OP_ERROR    = 2'd3;

  // sequencer mode
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_RX   = 2'd2;

  // request status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
  localparam logic [1:0] STATUS_BUSY     = 2'd2;
  localparam logic [1:0] STATUS_NONE     = 2'd3;

  // bus actions
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_WRITE_DR   = 3'd2;
  localparam logic [2:0] ACT_CLEAR_ADDR = 3'd3;
  localparam logic [2:0] ACT_STORED     = 3'd4;
  localparam logic [2:0] ACT_IRQ_OFF    = 3'd5;

  // completion codes
  localparam logic [1:0] DONE_NONE  = 2'd0;
  localparam logic [1:0] DONE_TX    = 2'd1;
  localparam logic [1:0] DONE_RX    = 2'd2;
  localparam logic [1:0] DONE_ABORT = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  slave_address;
    logic [15:0] transfer_length;
    logic        flag_start_sent;
    logic        flag_address_done;
    logic        flag_tx_empty;
    logic        flag_byte_finished;
    logic        flag_rx_full;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  request_status;
    logic [2:0]  bus_action;
    logic [7:0]  data_out;
    logic        stop_request;
    logic        ack_now;
    logic        irq_now;
    logic [7:0]  stored_byte;
    logic [15:0] byte_position;
    logic [1:0]  completion;
    logic [1:0]  mode_now;
  } result_t;

endpackage

>>> rtl/core/i2cmts_core.sv
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_macros.svh"

// Transfer state and the per-item decision logic. State advances on fire_i.
module i2cmts_core import i2cmts_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [1:0]            mode_q, mode_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] index_q, index_d;
  logic [7:0]            addr_byte_q, addr_byte_d;
  logic                  ack_q, ack_d;
  logic                  irq_q, irq_d;

  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS:0]   idx_inc;
  logic                  bytes_left;
  result_t               res;

  assign len        = item_i.transfer_length[COUNT_BITS-1:0];
  assign idx_inc    = {1'b0, index_q} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign bytes_left = index_q < total_q;

  always_comb begin
    mode_d      = mode_q;
    total_d     = total_q;
    index_d     = index_q;
    addr_byte_d = addr_byte_q;
    ack_d       = ack_q;
    irq_d       = irq_q;

    res                = '0;
    res.request_status = STATUS_NONE;
    res.bus_action     = ACT_NONE;
    res.completion     = DONE_NONE;

    case (item_i.opcode)
      OP_START_TX, OP_START_RX: begin
        if (len == '0) begin
          res.request_status = STATUS_ZERO_LEN;
        end else if (mode_q != MODE_IDLE) begin
          res.request_status = STATUS_BUSY;
        end else begin
          res.request_status = STATUS_OK;
          mode_d      = (item_i.opcode == OP_START_RX) ? MODE_RX : MODE_TX;
          total_d     = len;
          index_d     = '0;
          addr_byte_d = {item_i.slave_address, item_i.opcode[0]};
          if (item_i.opcode == OP_START_RX) begin
            ack_d = 1'b1;
          end
          irq_d          = 1'b1;
          res.bus_action = ACT_START;
        end
      end
      OP_EVENT: begin
        if (item_i.flag_start_sent) begin
          res.bus_action = ACT_WRITE_DR;
          res.data_out   = addr_byte_q;
        end else if (item_i.flag_address_done) begin
          res.bus_action = ACT_CLEAR_ADDR;
        end else if (item_i.flag_tx_empty && mode_q == MODE_TX && bytes_left) begin
          res.bus_action    = ACT_WRITE_DR;
          res.data_out      = item_i.tx_byte;
          res.byte_position = 16'(index_q);
          index_d           = idx_inc[COUNT_BITS-1:0];
        end else if (item_i.flag_byte_finished && mode_q == MODE_TX && !bytes_left) begin
          res.stop_request = 1'b1;
          irq_d            = 1'b0;
          mode_d           = MODE_IDLE;
          res.completion   = DONE_TX;
          res.bus_action   = ACT_IRQ_OFF;
        end else if (item_i.flag_rx_full && mode_q == MODE_RX) begin
          if (bytes_left) begin
            // last byte: NACK it and ask for stop before it is read
            if (idx_inc == {1'b0, total_q}) begin
              ack_d            = 1'b0;
              res.stop_request = 1'b1;
            end
            res.stored_byte   = item_i.rx_byte;
            res.byte_position = 16'(index_q);
            res.bus_action    = ACT_STORED;
            index_d           = idx_inc[COUNT_BITS-1:0];
            if (idx_inc[COUNT_BITS-1:0] >= total_q) begin
              irq_d          = 1'b0;
              mode_d         = MODE_IDLE;
              res.completion = DONE_RX;
            end
          end
        end else begin
          irq_d          = 1'b0;
          res.bus_action = ACT_IRQ_OFF;
        end
      end
      default: begin
        mode_d         = MODE_IDLE;
        irq_d          = 1'b0;
        res.completion = DONE_ABORT;
        res.bus_action = ACT_IRQ_OFF;
      end
    endcase

    res.ack_now  = ack_d;
    res.irq_now  = irq_d;
    res.mode_now = mode_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      total_q     <= '0;
      index_q     <= '0;
      addr_byte_q <= '0;
      ack_q       <= 1'b0;
      irq_q       <= 1'b0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      total_q     <= total_d;
      index_q     <= index_d;
      addr_byte_q <= addr_byte_d;
      ack_q       <= ack_d;
      irq_q       <= irq_d;
    end
  end

  // byte index never runs past the programmed length while busy
  `I2CMTS_ASSERT(a_index_in_range, clk_i, rst_ni, (mode_q == MODE_IDLE) || (index_q <= total_q))
  // a busy transfer always has a nonzero length
  `I2CMTS_ASSERT_NEVER(a_busy_zero_len, clk_i, rst_ni, (mode_q != MODE_IDLE) && (total_q == '0))
  // an error event always leaves the sequencer idle with interrupts off
  `I2CMTS_ASSERT(a_error_aborts, clk_i, rst_ni,
                 (fire_i && item_i.opcode == OP_ERROR) |=> (mode_q == MODE_IDLE && !irq_q))
  // an accepted start request restarts the byte index
  `I2CMTS_ASSERT(a_start_clears_index, clk_i, rst_ni,
                 (fire_i && res.bus_action == ACT_START) |=> (index_q == '0))

endmodule

>>> rtl/core/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps
// Master I2C transfer sequencer, one result per accepted item.
// An item enters the input register at its transfer edge and its result is then offered
// from the result register. Throughput: one item per cycle while the output is not stalled,
// set by the single decision stage that updates the transfer state.
// Reset: asynchronous, active low; mode idle, counts, address, ACK and IRQ
// enables cleared, both pipeline registers empty.
module i2c_master_transfer_sequencer import i2cmts_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_q;
  result_t core_result;

  logic out_free;
  logic advance;
  logic in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  i2cmts_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (s1_item_q),
    .result_o (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
    if (advance) begin
      out_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/tb_i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer;
  import i2cmts_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1850;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned HOLD_START    = 1500;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 10;

  // bus event flag masks, ordered {start sent, address done, tx empty, byte finished, rx full}
  localparam logic [4:0] F_NONE = 5'b00000;
  localparam logic [4:0] F_SB   = 5'b10000;
  localparam logic [4:0] F_ADDR = 5'b01000;
  localparam logic [4:0] F_TXE  = 5'b00100;
  localparam logic [4:0] F_BTF  = 5'b00010;
  localparam logic [4:0] F_RXNE = 5'b00001;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  item_t   in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;

  i2c_master_transfer_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  item_t   seq_items[$];
  result_t expected_results[$];
  int unsigned mismatches = 0;

  // shadow of the sequencer state
  logic [1:0]  cur_mode = MODE_IDLE;
  logic [15:0] byte_total = '0;
  logic [15:0] byte_idx = '0;
  logic [7:0]  addr_byte = '0;
  logic        ack_en = 1'b0;
  logic        irq_en = 1'b0;

  function automatic result_t step_sequencer(item_t it);
    result_t r;
    logic [15:0] len;
    r = '0;
    r.request_status = STATUS_NONE;
    r.bus_action = ACT_NONE;
    r.completion = DONE_NONE;
    len = it.transfer_length;
    if (it.opcode == OP_START_TX || it.opcode == OP_START_RX) begin
      if (len == '0) begin
        r.request_status = STATUS_ZERO_LEN;
      end else if (cur_mode != MODE_IDLE) begin
        r.request_status = STATUS_BUSY;
      end else begin
        r.request_status = STATUS_OK;
        cur_mode = (it.opcode == OP_START_TX) ? MODE_TX : MODE_RX;
        byte_total = len;
        byte_idx = '0;
        addr_byte = {it.slave_address, it.opcode == OP_START_RX};
        if (it.opcode == OP_START_RX) ack_en = 1'b1;
        irq_en = 1'b1;
        r.bus_action = ACT_START;
      end
    end else if (it.opcode == OP_EVENT) begin
      if (it.flag_start_sent) begin
        r.bus_action = ACT_WRITE_DR;
        r.data_out = addr_byte;
      end else if (it.flag_address_done) begin
        r.bus_action = ACT_CLEAR_ADDR;
      end else if (it.flag_tx_empty && cur_mode == MODE_TX && byte_idx < byte_total) begin
        r.bus_action = ACT_WRITE_DR;
        r.data_out = it.tx_byte;
        r.byte_position = byte_idx;
        byte_idx = byte_idx + 16'd1;
      end else if (it.flag_byte_finished && cur_mode == MODE_TX && byte_idx >= byte_total) begin
        r.stop_request = 1'b1;
        irq_en = 1'b0;
        cur_mode = MODE_IDLE;
        r.completion = DONE_TX;
        r.bus_action = ACT_IRQ_OFF;
      end else if (it.flag_rx_full && cur_mode == MODE_RX) begin
        // past the last byte nothing happens
        if (byte_idx < byte_total) begin
          // last byte: NACK it and ask for the stop
          if (byte_idx + 16'd1 == byte_total) begin
            ack_en = 1'b0;
            r.stop_request = 1'b1;
          end
          r.stored_byte = it.rx_byte;
          r.byte_position = byte_idx;
          r.bus_action = ACT_STORED;
          byte_idx = byte_idx + 16'd1;
          if (byte_idx >= byte_total) begin
            irq_en = 1'b0;
            cur_mode = MODE_IDLE;
            r.completion = DONE_RX;
          end
        end
      end else begin
        irq_en = 1'b0;
        r.bus_action = ACT_IRQ_OFF;
      end
    end else begin
      cur_mode = MODE_IDLE;
      irq_en = 1'b0;
      r.completion = DONE_ABORT;
      r.bus_action = ACT_IRQ_OFF;
    end
    r.ack_now = ack_en;
    r.irq_now = irq_en;
    r.mode_now = cur_mode;
    return r;
  endfunction

  function automatic item_t rand_item();
    logic [63:0] bits;
    item_t it;
    bits = {$urandom, $urandom};
    it = bits[$bits(item_t)-1:0];
    return it;
  endfunction

  function automatic item_t mk_req(logic [1:0] op, logic [6:0] addr, logic [15:0] len);
    item_t it;
    it = rand_item();
    it.opcode = op;
    it.slave_address = addr;
    it.transfer_length = len;
    return it;
  endfunction

  function automatic item_t mk_event(logic [4:0] flags, logic [7:0] txb, logic [7:0] rxb);
    item_t it;
    it = rand_item();
    it.opcode = OP_EVENT;
    {it.flag_start_sent, it.flag_address_done, it.flag_tx_empty,
     it.flag_byte_finished, it.flag_rx_full} = flags;
    it.tx_byte = txb;
    it.rx_byte = rxb;
    return it;
  endfunction

  function automatic item_t mk_error();
    item_t it;
    it = rand_item();
    it.opcode = OP_ERROR;
    return it;
  endfunction

  // request for a busy sequencer, random length so zero length shows up too
  task automatic add_stray_request();
    logic [1:0]  op;
    logic [15:0] len;
    op = $urandom_range(0, 1) ? OP_START_RX : OP_START_TX;
    len = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    seq_items.push_back(mk_req(op, 7'($urandom), len));
  endtask

  task automatic add_tx_transfer(int unsigned nbytes);
    logic [4:0] extra;
    seq_items.push_back(mk_req(OP_START_TX, 7'($urandom), 16'(nbytes)));
    seq_items.push_back(mk_event(F_SB | (5'($urandom) & 5'b01111), 8'($urandom), 8'($urandom)));
    seq_items.push_back(mk_event(F_ADDR | (5'($urandom) & 5'b00111), 8'($urandom), 8'($urandom)));
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) add_stray_request();
      extra = 5'($urandom) & (F_BTF | F_RXNE);
      seq_items.push_back(mk_event(F_TXE | extra, 8'($urandom), 8'($urandom)));
    end
    extra = 5'($urandom) & (F_TXE | F_RXNE);
    seq_items.push_back(mk_event(F_BTF | extra, 8'($urandom), 8'($urandom)));
  endtask

  task automatic add_rx_transfer(int unsigned nbytes);
    logic [4:0] extra;
    seq_items.push_back(mk_req(OP_START_RX, 7'($urandom), 16'(nbytes)));
    seq_items.push_back(mk_event(F_SB | (5'($urandom) & 5'b01111), 8'($urandom), 8'($urandom)));
    seq_items.push_back(mk_event(F_ADDR | (5'($urandom) & 5'b00111), 8'($urandom), 8'($urandom)));
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) add_stray_request();
      extra = 5'($urandom) & (F_TXE | F_BTF);
      seq_items.push_back(mk_event(F_RXNE | extra, 8'($urandom), 8'($urandom)));
    end
  endtask

  // long transfer cut short by a bus error
  task automatic add_aborted_transfer();
    logic [1:0]  op;
    logic [15:0] len;
    int unsigned nbytes;
    op = $urandom_range(0, 1) ? OP_START_RX : OP_START_TX;
    len = 16'($urandom_range(1, 65535));
    nbytes = $urandom_range(0, 6);
    seq_items.push_back(mk_req(op, 7'($urandom), len));
    seq_items.push_back(mk_event(F_SB, 8'($urandom), 8'($urandom)));
    seq_items.push_back(mk_event(F_ADDR, 8'($urandom), 8'($urandom)));
    for (int i = 0; i < nbytes; i++)
      seq_items.push_back(mk_event((op == OP_START_TX) ? F_TXE : F_RXNE,
                                   8'($urandom), 8'($urandom)));
    seq_items.push_back(mk_error());
  endtask

  task automatic add_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) seq_items.push_back(rand_item());
    // back to idle so the next transfer starts clean
    seq_items.push_back(mk_error());
  endtask

  task automatic fill_directed();
    // idle events fall to the final event branch, which turns interrupts off
    seq_items.push_back(mk_event(F_NONE, 8'h00, 8'h00));
    seq_items.push_back(mk_event(F_RXNE, 8'h00, 8'hff));
    seq_items.push_back(mk_event(F_BTF, 8'hff, 8'h00));
    seq_items.push_back(mk_req(OP_START_TX, 7'h7f, 16'h0000));
    seq_items.push_back(mk_req(OP_START_RX, 7'h00, 16'h0000));
    // single-byte transmit, request while busy, data-empty with nothing left
    seq_items.push_back(mk_req(OP_START_TX, 7'h7f, 16'h0001));
    seq_items.push_back(mk_req(OP_START_RX, 7'h55, 16'hffff));
    seq_items.push_back(mk_req(OP_START_TX, 7'h2a, 16'h0000));
    seq_items.push_back(mk_event(F_SB | F_ADDR | F_TXE | F_BTF | F_RXNE, 8'h00, 8'h00));
    seq_items.push_back(mk_event(F_ADDR | F_TXE, 8'h00, 8'h00));
    seq_items.push_back(mk_event(F_TXE | F_BTF, 8'hff, 8'h00));
    seq_items.push_back(mk_event(F_TXE, 8'h00, 8'h00));
    seq_items.push_back(mk_event(F_TXE | F_BTF, 8'h00, 8'h00));
    // two-byte receive, last byte NACKed
    seq_items.push_back(mk_req(OP_START_RX, 7'h00, 16'h0002));
    seq_items.push_back(mk_event(F_SB, 8'h00, 8'h00));
    seq_items.push_back(mk_event(F_ADDR, 8'h00, 8'h00));
    seq_items.push_back(mk_event(F_RXNE | F_TXE | F_BTF, 8'h00, 8'hff));
    seq_items.push_back(mk_event(F_RXNE, 8'hff, 8'h00));
    // maximum length transmit aborted, then error while idle
    seq_items.push_back(mk_req(OP_START_TX, 7'h7f, 16'hffff));
    seq_items.push_back(mk_event(F_TXE, 8'ha5, 8'h00));
    seq_items.push_back(mk_error());
    seq_items.push_back(mk_error());
    seq_items.push_back(mk_req(OP_START_RX, 7'h7f, 16'h8000));
    seq_items.push_back(mk_event(F_TXE | F_BTF, 8'h00, 8'h00));
    seq_items.push_back(mk_error());
  endtask

  initial begin
    int unsigned target;
    int unsigned sel;
    fill_directed();
    target = seq_items.size() + RANDOM_ITEMS;
    while (seq_items.size() < target) begin
      sel = $urandom_range(0, 9);
      if (sel <= 3)
        add_tx_transfer(($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      else if (sel <= 6)
        add_rx_transfer(($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      else if (sel == 7)
        add_aborted_transfer();
      else
        add_noise();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (seq_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // sender: bursts of random length, random gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(step_sequencer(in_data));
        seq_items.delete(0);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (seq_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= seq_items[0];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: phases of differing stall density, one long hold-off
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned phase_left = 0;
  int unsigned stall_pct = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        phase_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("request_status", 32'(want.request_status), 32'(out_data.request_status));
        check_field("bus_action", 32'(want.bus_action), 32'(out_data.bus_action));
        check_field("data_out", 32'(want.data_out), 32'(out_data.data_out));
        check_field("stop_request", 32'(want.stop_request), 32'(out_data.stop_request));
        check_field("ack_now", 32'(want.ack_now), 32'(out_data.ack_now));
        check_field("irq_now", 32'(want.irq_now), 32'(out_data.irq_now));
        check_field("stored_byte", 32'(want.stored_byte), 32'(out_data.stored_byte));
        check_field("byte_position", 32'(want.byte_position), 32'(out_data.byte_position));
        check_field("completion", 32'(want.completion), 32'(out_data.completion));
        check_field("mode_now", 32'(want.mode_now), 32'(out_data.mode_now));
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

endmodule
